>>> design/event_ring_queue_with_selective_take_core_defines.svh
// Assertion macros shared by the queue checker.
`ifndef EVENT_RING_QUEUE_WITH_SELECTIVE_TAKE_CORE_DEFINES_SVH
`define EVENT_RING_QUEUE_WITH_SELECTIVE_TAKE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define ERQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("erq check failed");

// Next-cycle implication, checked on every clock outside reset.
`define ERQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("erq check failed");

`endif

>>> design/erq_pkg.sv
// Types, request codes and the event-type to input-mask table of the event queue.
package erq_pkg;

   localparam int KIND_W    = 2;
   localparam int TYPE_W    = 7;
   localparam int WINDOW_W  = 32;
   localparam int PAYLOAD_W = 64;
   localparam int MASK_W    = 25;
   localparam int QCOUNT_W  = 6;

   localparam logic [KIND_W-1:0] KIND_PUSH      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP       = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TAKE_MASK = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TAKE_TYPE = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [TYPE_W-1:0]    event_type;
      logic [WINDOW_W-1:0]  event_window;
      logic [PAYLOAD_W-1:0] event_payload;
      logic [MASK_W-1:0]    select_mask;
   } req_type;

   typedef struct packed {
      logic                 success;
      logic [TYPE_W-1:0]    out_type;
      logic [WINDOW_W-1:0]  out_window;
      logic [PAYLOAD_W-1:0] out_payload;
      logic [QCOUNT_W-1:0]  queue_count;
   } rsp_type;

   // One queued event as held in a ring slot.
   typedef struct packed {
      logic [TYPE_W-1:0]    ev_type;
      logic [WINDOW_W-1:0]  ev_window;
      logic [PAYLOAD_W-1:0] ev_payload;
   } slot_type;

   // Input-mask bits selected by an event type; unmaskable types give zero.
   function automatic logic [MASK_W-1:0] type_to_mask(input logic [TYPE_W-1:0] t);
      logic [MASK_W-1:0] m;
      m = '0;
      case (t) inside
         7'd2:  m[0] = 1'b1;
         7'd3:  m[1] = 1'b1;
         7'd4:  m[2] = 1'b1;
         7'd5:  m[3] = 1'b1;
         7'd6: begin
            m[6]  = 1'b1;
            m[13] = 1'b1;
         end
         7'd7:  m[4] = 1'b1;
         7'd8:  m[5] = 1'b1;
         7'd9, 7'd10: m[21] = 1'b1;
         7'd11: m[14] = 1'b1;
         7'd12: m[15] = 1'b1;
         7'd15: m[16] = 1'b1;
         7'd16: m[19] = 1'b1;
         7'd17, 7'd18, 7'd19, 7'd21, 7'd22, 7'd24, 7'd26: begin
            m[17] = 1'b1;
            m[19] = 1'b1;
         end
         7'd20, 7'd23, 7'd27: m[20] = 1'b1;
         7'd25: m[18] = 1'b1;
         7'd28: m[22] = 1'b1;
         7'd32: m[23] = 1'b1;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

>>> design/erq_match.sv
// Compare unit: decides whether one queued event satisfies the pending request.
module erq_match (
   input  erq_pkg::req_type  req,
   input  erq_pkg::slot_type slot,
   output logic              hit
);

   always_comb begin
      unique case (req.kind)
         erq_pkg::KIND_PUSH:      hit = 1'b0;
         erq_pkg::KIND_POP:       hit = 1'b1;
         erq_pkg::KIND_TAKE_MASK:
            hit = |(erq_pkg::type_to_mask(slot.ev_type) & req.select_mask);
         erq_pkg::KIND_TAKE_TYPE:
            hit = (slot.ev_type == req.event_type) && (slot.ev_window == req.event_window);
         default:                 hit = 1'b0;
      endcase
   end

endmodule

>>> design/event_ring_queue_with_selective_take_core.sv
// Steps from accept to result: a push is written in ST_START; a pop or take scans from the head,
// reading the slot memory one slot at a time, and a take then moves each later slot down to close
// the gap; the result is then held in ST_DONE while the output register is stalled by rsp_stall.
// Throughput: one item at a time; req_stall is low only while the sequencer is idle, so a new
// request is not accepted until the last one's result has been loaded into the output register.
// Reset clears head, tail, count and handshake state; slot memory is not cleared.
module event_ring_queue_with_selective_take_core #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  erq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output erq_pkg::rsp_type rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = (AW > erq_pkg::QCOUNT_W) ? AW : erq_pkg::QCOUNT_W;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_START    = 7'b0000010,
      ST_SCAN_RD  = 7'b0000100,
      ST_SCAN_CHK = 7'b0001000,
      ST_SHIFT_RD = 7'b0010000,
      ST_SHIFT_WR = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
      return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
      return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
   endfunction

   state_type          state_ff, state_in;
   erq_pkg::req_type   req_ff, req_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic [AW-1:0]      count_ff, count_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               res_ok_ff, res_ok_in;
   erq_pkg::slot_type  res_slot_ff, res_slot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   erq_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   erq_pkg::slot_type  slot_ff [DEPTH];
   erq_pkg::slot_type  rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   erq_pkg::slot_type  mem_wdata;
   logic [AW-1:0]      mem_raddr;

   logic               hit;
   logic [AW-1:0]      nx_pos;
   logic [CW-1:0]      count_wide;

   erq_match u_match (
      .req  (req_ff),
      .slot (rd_data_ff),
      .hit  (hit)
   );

   assign nx_pos     = ring_next(pos_ff);
   assign count_wide = CW'(count_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      res_ok_in    = res_ok_ff;
      res_slot_in  = res_slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = tail_ff;
      mem_wdata    = '{ev_type: req_ff.event_type, ev_window: req_ff.event_window,
                       ev_payload: req_ff.event_payload};
      mem_raddr    = pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               res_ok_in   = 1'b0;
               res_slot_in = '0;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            pos_in = head_ff;
            idx_in = '0;
            if (req_ff.kind == erq_pkg::KIND_PUSH) begin
               // drop the item when the ring is full
               if (count_ff != AW'(DEPTH - 1)) begin
                  mem_we    = 1'b1;
                  tail_in   = ring_next(tail_ff);
                  count_in  = count_ff + AW'(1);
                  res_ok_in = 1'b1;
               end
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (hit) begin
               res_ok_in   = 1'b1;
               res_slot_in = rd_data_ff;
               if (req_ff.kind == erq_pkg::KIND_POP) begin
                  head_in  = ring_next(head_ff);
                  count_in = count_ff - AW'(1);
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SHIFT_RD;
               end
            end else begin
               pos_in   = nx_pos;
               idx_in   = idx_ff + AW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            // close the gap one slot at a time, then drop the tail
            mem_raddr = nx_pos;
            if (nx_pos == tail_ff) begin
               tail_in  = ring_prev(tail_ff);
               count_in = count_ff - AW'(1);
               state_in = ST_DONE;
            end else begin
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = rd_data_ff;
            pos_in    = nx_pos;
            state_in  = ST_SHIFT_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.success     = res_ok_ff;
               rsp_data_in.out_type    = res_slot_ff.ev_type;
               rsp_data_in.out_window  = res_slot_ff.ev_window;
               rsp_data_in.out_payload = res_slot_ff.ev_payload;
               rsp_data_in.queue_count = count_wide[erq_pkg::QCOUNT_W-1:0];
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      res_ok_ff   <= res_ok_in;
      res_slot_ff <= res_slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_ff[mem_raddr];
   end

endmodule

>>> design/erq_checker.sv
// Port-level checker for the event queue and its bind to the top level.
`include "event_ring_queue_with_selective_take_core_defines.svh"

module erq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input erq_pkg::rsp_type rsp_data
);

   logic fields_zero;

   assign fields_zero = (rsp_data.out_type == '0) && (rsp_data.out_window == '0) &&
                        (rsp_data.out_payload == '0);

   // a stalled result holds
   `ERQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // one item at a time: busy right after an accept
   `ERQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // a result only comes out of a busy sequencer
   `ERQ_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall))
   // nothing removed means zero event fields
   `ERQ_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_data.success, fields_zero)

endmodule

bind event_ring_queue_with_selective_take_core erq_checker u_erq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/sv/tb.sv
// Self-checking bench for the event ring queue: random request stream against a scoreboard.
module tb;

   localparam int SLOTS         = 64;
   localparam int RANDOM_ITEMS  = 550;
   localparam int HOLD_AT       = 150;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 2 * SLOTS + 40;
   localparam int CYCLE_LIMIT   = 600000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   erq_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   erq_pkg::rsp_type rsp_data;

   erq_pkg::req_type  pending_reqs[$];
   erq_pkg::rsp_type  expected_rsps[$];
   erq_pkg::slot_type held_events[$];
   erq_pkg::slot_type recent_keys[$];

   int unsigned error_count  = 0;
   int unsigned rsp_seen     = 0;
   int unsigned random_count = 0;
   int unsigned cycle_count  = 0;
   int unsigned send_gap     = 0;
   int unsigned send_calm    = 0;
   int unsigned recv_wait    = 0;
   int unsigned recv_calm    = 0;

   event_ring_queue_with_selective_take_core #(.DEPTH(SLOTS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Input-mask bits that an event type answers to; zero for unmaskable types.
   function automatic logic [erq_pkg::MASK_W-1:0] mask_of_type(
         logic [erq_pkg::TYPE_W-1:0] t);
      logic [erq_pkg::MASK_W-1:0] one;
      one = '0;
      one[0] = 1'b1;
      case (t)
         2:  return one << 0;
         3:  return one << 1;
         4:  return one << 2;
         5:  return one << 3;
         6:  return (one << 6) | (one << 13);
         7:  return one << 4;
         8:  return one << 5;
         9, 10: return one << 21;
         11: return one << 14;
         12: return one << 15;
         15: return one << 16;
         16: return one << 19;
         17, 18, 19, 21, 22, 24, 26: return (one << 17) | (one << 19);
         20, 23, 27: return one << 20;
         25: return one << 18;
         28: return one << 22;
         32: return one << 23;
         default: return '0;
      endcase
   endfunction

   // Apply one request to the shadow queue and return the result it must give.
   function automatic erq_pkg::rsp_type predict_rsp(erq_pkg::req_type r);
      erq_pkg::rsp_type  res;
      erq_pkg::slot_type ev;
      int                hit_at;
      int                i;
      res = '0;
      hit_at = -1;
      case (r.kind)
         erq_pkg::KIND_PUSH: begin
            if (held_events.size() < SLOTS - 1) begin
               ev.ev_type    = r.event_type;
               ev.ev_window  = r.event_window;
               ev.ev_payload = r.event_payload;
               held_events.push_back(ev);
               res.success = 1'b1;
            end
         end
         erq_pkg::KIND_POP: begin
            if (held_events.size() != 0) hit_at = 0;
         end
         erq_pkg::KIND_TAKE_MASK: begin
            for (i = 0; i < held_events.size(); i++) begin
               if ((mask_of_type(held_events[i].ev_type) & r.select_mask) != 0) begin
                  hit_at = i;
                  break;
               end
            end
         end
         default: begin
            for (i = 0; i < held_events.size(); i++) begin
               if (held_events[i].ev_type == r.event_type &&
                   held_events[i].ev_window == r.event_window) begin
                  hit_at = i;
                  break;
               end
            end
         end
      endcase
      if (hit_at >= 0) begin
         ev = held_events[hit_at];
         held_events.delete(hit_at);
         res.success     = 1'b1;
         res.out_type    = ev.ev_type;
         res.out_window  = ev.ev_window;
         res.out_payload = ev.ev_payload;
      end
      res.queue_count = erq_pkg::QCOUNT_W'(held_events.size());
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0d] mismatch: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic check_rsp(input erq_pkg::rsp_type got);
      erq_pkg::rsp_type want;
      if (expected_rsps.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with nothing expected", rsp_seen));
      end else begin
         want = expected_rsps.pop_front();
         if (got.success !== want.success)
            report_mismatch($sformatf("result %0d success %b, want %b",
                                      rsp_seen, got.success, want.success));
         if (got.out_type !== want.out_type)
            report_mismatch($sformatf("result %0d out_type %0d, want %0d",
                                      rsp_seen, got.out_type, want.out_type));
         if (got.out_window !== want.out_window)
            report_mismatch($sformatf("result %0d out_window %h, want %h",
                                      rsp_seen, got.out_window, want.out_window));
         if (got.out_payload !== want.out_payload)
            report_mismatch($sformatf("result %0d out_payload %h, want %h",
                                      rsp_seen, got.out_payload, want.out_payload));
         if (got.queue_count !== want.queue_count)
            report_mismatch($sformatf("result %0d queue_count %0d, want %0d",
                                      rsp_seen, got.queue_count, want.queue_count));
      end
   endtask

   // Draw the idle gap before the next item, with occasional runs of back-to-back items.
   task automatic draw_wait(inout int unsigned calm_left, output int unsigned wait_cycles);
      if (calm_left != 0) begin
         calm_left--;
         wait_cycles = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 40);
         wait_cycles = 0;
      end else begin
         wait_cycles = $urandom_range(0, 17);
      end
   endtask

   function automatic erq_pkg::req_type make_req(logic [erq_pkg::KIND_W-1:0] kind,
                                                 logic [erq_pkg::TYPE_W-1:0] t,
                                                 logic [erq_pkg::WINDOW_W-1:0] w,
                                                 logic [erq_pkg::PAYLOAD_W-1:0] p,
                                                 logic [erq_pkg::MASK_W-1:0] m);
      erq_pkg::req_type r;
      r.kind          = kind;
      r.event_type    = t;
      r.event_window  = w;
      r.event_payload = p;
      r.select_mask   = m;
      return r;
   endfunction

   function automatic logic [erq_pkg::TYPE_W-1:0] pick_type();
      if ($urandom_range(0, 9) < 3) return erq_pkg::TYPE_W'($urandom_range(0, 127));
      return erq_pkg::TYPE_W'($urandom_range(0, 33));
   endfunction

   function automatic logic [erq_pkg::WINDOW_W-1:0] pick_window();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return 32'h0040_0001;
         3: return 32'h0040_0002;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [erq_pkg::MASK_W-1:0] pick_mask();
      logic [erq_pkg::MASK_W-1:0] m;
      case ($urandom_range(0, 9))
         0: m = '0;
         1: m = '1;
         2, 3: m = erq_pkg::MASK_W'($urandom);
         default: begin
            m = '0;
            m[0] = 1'b1;
            m = m << $urandom_range(0, 24);
            if ($urandom_range(0, 2) == 0) m[$urandom_range(0, 24)] = 1'b1;
         end
      endcase
      return m;
   endfunction

   task automatic queue_random(input logic [erq_pkg::KIND_W-1:0] kind);
      erq_pkg::req_type  r;
      erq_pkg::slot_type key;
      r = make_req(kind, pick_type(), pick_window(), {$urandom, $urandom}, pick_mask());
      if (kind == erq_pkg::KIND_PUSH) begin
         key.ev_type    = r.event_type;
         key.ev_window  = r.event_window;
         key.ev_payload = '0;
         recent_keys.push_back(key);
         if (recent_keys.size() > 16) void'(recent_keys.pop_front());
      end else if (kind == erq_pkg::KIND_TAKE_TYPE && recent_keys.size() != 0 &&
                   $urandom_range(0, 9) < 6) begin
         // aim at something likely still queued
         key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
         r.event_type   = key.ev_type;
         r.event_window = key.ev_window;
      end
      pending_reqs.push_back(r);
      random_count++;
   endtask

   // Driver: predict at acceptance, then present the next item after its gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_rsps.push_back(predict_rsp(req_data));
         if (send_gap != 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            draw_wait(send_calm, send_gap);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each item taken, then stall for a drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_rsp(rsp_data);
            rsp_seen++;
            draw_wait(recv_calm, recv_wait);
            // hold off long enough for the input side to back up
            if (rsp_seen == HOLD_AT) recv_wait = HOLD_CYCLES;
         end else if (recv_wait != 0) begin
            recv_wait = recv_wait - 1;
         end
         rsp_stall <= (recv_wait != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("event_ring_queue_with_selective_take_core regression: fail");
         $finish;
      end
   end

   initial begin
      int unsigned                len;
      int unsigned                pick;
      logic [erq_pkg::KIND_W-1:0] kind;
      logic [erq_pkg::MASK_W-1:0] bit23;

      bit23 = '0;
      bit23[23] = 1'b1;

      // empty queue: every removal misses
      pending_reqs.push_back(make_req(erq_pkg::KIND_POP, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(erq_pkg::KIND_TAKE_MASK, 0, 0, 0, '1));
      pending_reqs.push_back(make_req(erq_pkg::KIND_TAKE_TYPE, 6, 0, 0, 0));
      // field extremes and a mix of maskable types
      pending_reqs.push_back(make_req(erq_pkg::KIND_PUSH, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(erq_pkg::KIND_PUSH, 127, '1, '1, '1));
      pending_reqs.push_back(make_req(erq_pkg::KIND_PUSH, 6, 32'h0000_00a0, 64'h1111, 0));
      pending_reqs.push_back(make_req(erq_pkg::KIND_PUSH, 32, 32'h0000_00a0, 64'h2222, 0));
      pending_reqs.push_back(make_req(erq_pkg::KIND_PUSH, 17, 32'h0000_00b0, 64'h3333, 0));
      pending_reqs.push_back(make_req(erq_pkg::KIND_PUSH, 6, 32'h0000_00b0, 64'h4444, 0));
      // empty mask never matches
      pending_reqs.push_back(make_req(erq_pkg::KIND_TAKE_MASK, 0, 0, 0, 0));
      // takes from the middle close the gap
      pending_reqs.push_back(make_req(erq_pkg::KIND_TAKE_MASK, 0, 0, 0, 25'h000_2000));
      pending_reqs.push_back(make_req(erq_pkg::KIND_TAKE_TYPE, 127, '1, 0, 0));
      // type matches but window does not
      pending_reqs.push_back(make_req(erq_pkg::KIND_TAKE_TYPE, 6, 32'h0000_00c0, 0, 0));
      pending_reqs.push_back(make_req(erq_pkg::KIND_TAKE_MASK, 0, 0, 0, bit23));
      pending_reqs.push_back(make_req(erq_pkg::KIND_POP, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(erq_pkg::KIND_TAKE_TYPE, 6, 32'h0000_00b0, 0, 0));
      pending_reqs.push_back(make_req(erq_pkg::KIND_TAKE_MASK, 0, 0, 0, '1));
      pending_reqs.push_back(make_req(erq_pkg::KIND_POP, 0, 0, 0, 0));
      // unmaskable type stays put under a full mask
      pending_reqs.push_back(make_req(erq_pkg::KIND_PUSH, 1, 32'h0000_00d0, 64'h5555, 0));
      pending_reqs.push_back(make_req(erq_pkg::KIND_TAKE_MASK, 0, 0, 0, '1));
      pending_reqs.push_back(make_req(erq_pkg::KIND_POP, 0, 0, 0, 0));

      while (random_count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 4))
            0: begin
               // fill up to or past full so pushes can get dropped
               len = $urandom_range(60, 72);
               repeat (len) queue_random(erq_pkg::KIND_PUSH);
            end
            1: begin
               len = $urandom_range(20, 70);
               repeat (len) begin
                  pick = $urandom_range(0, 2);
                  kind = (pick == 0) ? erq_pkg::KIND_POP :
                         (pick == 1) ? erq_pkg::KIND_TAKE_MASK : erq_pkg::KIND_TAKE_TYPE;
                  queue_random(kind);
               end
            end
            default: begin
               len = $urandom_range(20, 40);
               repeat (len) begin
                  pick = $urandom_range(0, 99);
                  kind = (pick < 40) ? erq_pkg::KIND_PUSH :
                         (pick < 55) ? erq_pkg::KIND_POP :
                         (pick < 80) ? erq_pkg::KIND_TAKE_MASK : erq_pkg::KIND_TAKE_TYPE;
                  queue_random(kind);
               end
            end
         endcase
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_rsps.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));

      if (error_count == 0)
         $display("event_ring_queue_with_selective_take_core regression: pass");
      else
         $display("event_ring_queue_with_selective_take_core regression: fail");
      $finish;
   end

endmodule
